// File: src/bq_pkg.sv
// Shared types, widths, register indexes and the microcode program of the biquad block.
// No dependencies; compile first.
package bq_pkg;

    // Sample and coefficient formats
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
    localparam int STATE_BITS     = 40;
    localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
    localparam int WIDE_BITS      = (PROD_BITS > STATE_BITS) ? PROD_BITS : STATE_BITS;
    localparam int ACC_BITS       = WIDE_BITS + 2;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEF_BITS-1:0]   t_coef;
    typedef logic signed [STATE_BITS-1:0]  t_state;
    typedef logic signed [ACC_BITS-1:0]    t_acc;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_B0     = 3'd0;
    localparam t_cfg_idx REG_B1     = 3'd1;
    localparam t_cfg_idx REG_B2     = 3'd2;
    localparam t_cfg_idx REG_A1     = 3'd3;
    localparam t_cfg_idx REG_A2     = 3'd4;
    localparam t_cfg_idx REG_BYPASS = 3'd5;

    localparam t_coef COEF_ONE = t_coef'(1) <<< COEF_FRAC_BITS;

    // Multiplier coefficient select codes
    localparam logic [2:0] MC_B0 = 3'd0;
    localparam logic [2:0] MC_B1 = 3'd1;
    localparam logic [2:0] MC_B2 = 3'd2;
    localparam logic [2:0] MC_A1 = 3'd3;
    localparam logic [2:0] MC_A2 = 3'd4;

    // Multiplier sample select codes
    localparam logic MS_X = 1'b0;
    localparam logic MS_Y = 1'b1;

    // Accumulator addend select codes
    localparam logic [1:0] AS_ZERO = 2'd0;
    localparam logic [1:0] AS_D1R  = 2'd1;
    localparam logic [1:0] AS_D2   = 2'd2;
    localparam logic [1:0] AS_ACC  = 2'd3;

    // One control word per program step
    typedef struct packed {
        logic [2:0] mul_coef;  // coefficient operand
        logic       mul_src;   // sample operand: input or rounded output
        logic [1:0] add_src;   // addend of the accumulator update
        logic       neg;       // subtract the product instead of adding it
        logic       ld_y;      // latch the rounded output and check its range
        logic       ld_n1;     // latch next first delay and check its range
        logic       jmp_pass;  // jump to the end when bypass or fault holds
        logic       last;      // final step: commit delays, emit result
    } t_ucode;

    localparam int NUM_STEPS = 5;
    localparam int STEP_BITS = $clog2(NUM_STEPS);
    typedef logic [STEP_BITS-1:0] t_step;

    // Program:
    //   0: acc = b0*x + d1 + half LSB           (jump out on bypass/fault)
    //   1: y = round(acc); acc = b1*x + d2
    //   2: acc = acc - a1*y
    //   3: n1 = acc; acc = b2*x
    //   4: n2 = acc - a2*y; commit
    function automatic t_ucode ucode_rom(t_step step);
        t_ucode w;
        w = '0;
        case (step)
            t_step'(0): begin
                w.mul_coef = MC_B0; w.mul_src = MS_X; w.add_src = AS_D1R; w.jmp_pass = 1'b1;
            end
            t_step'(1): begin
                w.mul_coef = MC_B1; w.mul_src = MS_X; w.add_src = AS_D2; w.ld_y = 1'b1;
            end
            t_step'(2): begin
                w.mul_coef = MC_A1; w.mul_src = MS_Y; w.add_src = AS_ACC; w.neg = 1'b1;
            end
            t_step'(3): begin
                w.mul_coef = MC_B2; w.mul_src = MS_X; w.add_src = AS_ZERO; w.ld_n1 = 1'b1;
            end
            t_step'(4): begin
                w.mul_coef = MC_A2; w.mul_src = MS_Y; w.add_src = AS_ACC; w.neg = 1'b1;
                w.last = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// File: src/bq_sample_in_if.sv
// Input sample channel: valid/ready handshake carrying one signed sample.
// Depends on bq_pkg.
interface bq_sample_in_if;
    import bq_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// File: src/bq_sample_out_if.sv
// Result channel: valid/ready handshake carrying the output sample and pass flag.
// Depends on bq_pkg.
interface bq_sample_out_if;
    import bq_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample_out;
    logic    passed_through;

    modport source (output valid, output sample_out, output passed_through, input ready);
    modport sink   (input valid, input sample_out, input passed_through, output ready);
endinterface

// File: src/biquad_iir_filter_with_fault_bypass_top.sv
// Biquad IIR section (transposed direct form II) with overflow fault and bypass.
// Depends on bq_pkg, bq_sample_in_if and bq_sample_out_if.
//
// Usage:
//   i_sample carries one signed Q1.15 sample per transaction; o_result returns
//   one transaction per sample: the filtered sample, or the input itself with
//   passed_through set when bypass is on or a fault is latched or trips.
//   Coefficients (Q2.16) and bypass go in via i_cfg_we/i_cfg_index/i_cfg_data;
//   the user must write them while the block is idle, the block does not check;
//   any valid write clears the fault; enabling bypass clears both delay states.
// Sequencing:
//   A filtered sample runs through a five-step microcode program that drives
//   one shared 18x16 multiplier and one accumulator, one product per cycle
//   while the output is not stalled. A bypassed sample leaves at step 0.
//   One sample is processed at a time; input ready returns in the cycle after
//   the program has handed its result to the output register, so no new
//   sample is taken before the last one is through, bypassed or not.
// Reset and stall:
//   Reset loads b0 = 1.0, other coefficients 0, bypass on, delays and fault 0.
//   If the receiver stalls, the result waits in the output register and the
//   program holds on its finishing step until the register frees up.
module biquad_iir_filter_with_fault_bypass_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  bq_pkg::t_cfg_idx         i_cfg_index,
    input  logic [bq_pkg::COEF_BITS-1:0] i_cfg_data,
    bq_sample_in_if.sink             i_sample,
    bq_sample_out_if.source          o_result
);
    import bq_pkg::*;

    localparam t_acc ROUND_HALF = t_acc'(1) <<< (COEF_FRAC_BITS - 1);

    // Configuration and filter state
    t_coef  r_b0, r_b1, r_b2, r_a1, r_a2;
    logic   r_bypass;
    logic   r_fault;
    t_state r_d1, r_d2;

    // Sequencer and datapath registers
    logic    r_busy;
    t_step   r_step;
    t_sample r_x;
    t_sample r_y;
    t_acc    r_acc;
    t_state  r_n1;
    logic    r_ovf;

    // Output register
    logic    r_out_valid;
    t_sample r_out_sample;
    logic    r_out_pass;

    t_ucode                      cw;
    t_coef                       mul_a;
    t_sample                     mul_b;
    logic signed [PROD_BITS-1:0] prod;
    t_acc                        prod_ext;
    t_acc                        addend;
    t_acc                        n_acc;
    logic                        pass_now;
    logic                        finishing;
    logic                        out_free;
    logic                        advance;
    logic                        y_ovf;
    logic                        n1_ovf;
    logic                        n2_ovf;
    logic                        fault_now;
    logic                        cfg_hit;

    // Decode the current step
    assign cw = ucode_rom(r_step);

    // Operand selection and shared multiplier
    always_comb begin
        case (cw.mul_coef)
            MC_B0:   mul_a = r_b0;
            MC_B1:   mul_a = r_b1;
            MC_B2:   mul_a = r_b2;
            MC_A1:   mul_a = r_a1;
            MC_A2:   mul_a = r_a2;
            default: mul_a = '0;
        endcase
    end

    assign mul_b    = (cw.mul_src == MS_Y) ? r_y : r_x;
    assign prod     = mul_a * mul_b;
    assign prod_ext = t_acc'(prod);

    // Accumulator update
    always_comb begin
        case (cw.add_src)
            AS_ZERO: addend = '0;
            AS_D1R:  addend = t_acc'(r_d1) + ROUND_HALF;
            AS_D2:   addend = t_acc'(r_d2);
            AS_ACC:  addend = r_acc;
            default: addend = '0;
        endcase
    end

    assign n_acc = cw.neg ? (addend - prod_ext) : (addend + prod_ext);

    // Range checks: the dropped high bits must all equal the kept sign bit
    assign y_ovf  = !((&r_acc[ACC_BITS-1:COEF_FRAC_BITS+SAMPLE_BITS-1]) ||
                      (~|r_acc[ACC_BITS-1:COEF_FRAC_BITS+SAMPLE_BITS-1]));
    assign n1_ovf = !((&r_acc[ACC_BITS-1:STATE_BITS-1]) ||
                      (~|r_acc[ACC_BITS-1:STATE_BITS-1]));
    assign n2_ovf = !((&n_acc[ACC_BITS-1:STATE_BITS-1]) ||
                      (~|n_acc[ACC_BITS-1:STATE_BITS-1]));
    assign fault_now = r_ovf || n2_ovf;

    // Sequencing control
    assign pass_now  = r_bypass || r_fault;
    assign finishing = r_busy && (cw.last || (cw.jmp_pass && pass_now));
    assign out_free  = !r_out_valid || o_result.ready;
    assign advance   = r_busy && (!finishing || out_free);

    assign cfg_hit = i_cfg_we && (i_cfg_index <= REG_BYPASS);

    assign i_sample.ready = !r_busy;

    // Configuration registers, fault flag and delay states
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0     <= COEF_ONE;
            r_b1     <= '0;
            r_b2     <= '0;
            r_a1     <= '0;
            r_a2     <= '0;
            r_bypass <= 1'b1;
            r_fault  <= 1'b0;
            r_d1     <= '0;
            r_d2     <= '0;
        end else begin
            if (cfg_hit) begin
                r_fault <= 1'b0;
                case (i_cfg_index)
                    REG_B0: r_b0 <= i_cfg_data;
                    REG_B1: r_b1 <= i_cfg_data;
                    REG_B2: r_b2 <= i_cfg_data;
                    REG_A1: r_a1 <= i_cfg_data;
                    REG_A2: r_a2 <= i_cfg_data;
                    REG_BYPASS: begin
                        r_bypass <= i_cfg_data[0];
                        if (i_cfg_data[0]) begin
                            r_d1 <= '0;
                            r_d2 <= '0;
                        end
                    end
                    default: begin
                        r_fault <= 1'b0;
                    end
                endcase
            end else if (finishing && out_free) begin
                // Commit on the final step, or clear on pass-through and fault
                if (pass_now || fault_now) begin
                    r_d1 <= '0;
                    r_d2 <= '0;
                    if (!pass_now) begin
                        r_fault <= 1'b1;
                    end
                end else begin
                    r_d1 <= r_n1;
                    r_d2 <= n_acc[STATE_BITS-1:0];
                end
            end
        end
    end

    // Step counter: start on accept, advance each cycle unless the finish stalls, end on last or jump
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_sample.valid && !r_busy) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (advance) begin
            if (finishing) begin
                r_busy <= 1'b0;
                r_step <= '0;
            end else begin
                r_step <= r_step + t_step'(1);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_sample.valid && !r_busy) begin
            r_x <= i_sample.sample_in;
        end
        if (advance) begin
            r_acc <= n_acc;
            if (cw.ld_y) begin
                r_y   <= r_acc[COEF_FRAC_BITS+SAMPLE_BITS-1:COEF_FRAC_BITS];
                r_ovf <= y_ovf;
            end
            if (cw.ld_n1) begin
                r_n1  <= r_acc[STATE_BITS-1:0];
                r_ovf <= r_ovf || n1_ovf;
            end
        end
    end

    // Output register: load on finish, drop once the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finishing && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finishing && out_free) begin
            if (pass_now || fault_now) begin
                r_out_sample <= r_x;
                r_out_pass   <= 1'b1;
            end else begin
                r_out_sample <= r_y;
                r_out_pass   <= 1'b0;
            end
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.sample_out     = r_out_sample;
    assign o_result.passed_through = r_out_pass;

endmodule

// File: tb/sv/tb_bq_tracker_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the biquad testbench: tracks filter state and config and queues expected outputs.
// Depends on bq_pkg.
package tb_bq_tracker_pkg;
    import bq_pkg::*;

    // One expected output transaction
    typedef struct packed {
        t_sample y;
        logic    pass;
    } t_filtered;

    class biquad_tracker;
        t_coef     b0, b1, b2, a1, a2;
        bit        bypass_on;
        bit        fault_on;
        t_state    d1, d2;
        t_filtered filtered_q[$];
        int        mismatches;
        int        samples_in;
        int        filtered_cnt;
        int        passed_cnt;
        int        faults_cnt;

        function new();
            b0        = COEF_ONE;
            b1        = '0;
            b2        = '0;
            a1        = '0;
            a2        = '0;
            bypass_on = 1'b1;
            fault_on  = 1'b0;
            d1        = '0;
            d2        = '0;
        endfunction

        static function bit fits_width(longint v, int w);
            longint lim;
            lim = longint'(1) <<< (w - 1);
            return (v >= -lim) && (v < lim);
        endfunction

        // Mirror a register write; only listed registers clear the fault
        function void write_reg(t_cfg_idx idx, logic [COEF_BITS-1:0] data);
            case (idx)
                REG_B0: b0 = t_coef'(data);
                REG_B1: b1 = t_coef'(data);
                REG_B2: b2 = t_coef'(data);
                REG_A1: a1 = t_coef'(data);
                REG_A2: a2 = t_coef'(data);
                REG_BYPASS: begin
                    bypass_on = data[0];
                    if (data[0]) begin
                        d1 = '0;
                        d2 = '0;
                    end
                end
                default: return;
            endcase
            fault_on = 1'b0;
        endfunction

        // Run one sample through the section and queue the expected output
        function void take_sample(t_sample x);
            t_filtered e;
            longint    acc, y, n1, n2;
            bit        ovf;
            samples_in++;
            if (bypass_on || fault_on) begin
                d1     = '0;
                d2     = '0;
                e.y    = x;
                e.pass = 1'b1;
                passed_cnt++;
            end else begin
                acc = longint'(b0) * longint'(x) + longint'(d1)
                    + (longint'(1) <<< (COEF_FRAC_BITS - 1));
                y   = acc >>> COEF_FRAC_BITS;
                ovf = !fits_width(y, SAMPLE_BITS);
                n1  = longint'(b1) * longint'(x) - longint'(a1) * y + longint'(d2);
                n2  = longint'(b2) * longint'(x) - longint'(a2) * y;
                if (ovf || !fits_width(n1, STATE_BITS) || !fits_width(n2, STATE_BITS)) begin
                    // trip: latch fault, drop state, pass the input
                    fault_on = 1'b1;
                    d1       = '0;
                    d2       = '0;
                    e.y      = x;
                    e.pass   = 1'b1;
                    faults_cnt++;
                    passed_cnt++;
                end else begin
                    d1     = t_state'(n1);
                    d2     = t_state'(n2);
                    e.y    = t_sample'(y);
                    e.pass = 1'b0;
                    filtered_cnt++;
                end
            end
            filtered_q.push_back(e);
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %0d: %s", mismatches, msg);
        endfunction

        // Compare one output transaction with the oldest expectation
        function void check_output(t_sample y, logic pass);
            t_filtered e;
            if (filtered_q.size() == 0) begin
                note_mismatch($sformatf("output y=%0d pass=%0b with nothing pending", y, pass));
                return;
            end
            e = filtered_q.pop_front();
            if (e.y !== y || e.pass !== pass)
                note_mismatch($sformatf("expected y=%0d pass=%0b, got y=%0d pass=%0b",
                                        e.y, e.pass, y, pass));
        endfunction

        function int pending();
            return filtered_q.size();
        endfunction
    endclass

endpackage

// File: tb/sv/tb_biquad_iir_filter_with_fault_bypass_top.sv
`timescale 1ns / 100ps
// Top-level testbench for the biquad IIR section: directed and random samples, config phases.
// Depends on bq_pkg, both channel interfaces, tb_bq_tracker_pkg and the block itself.
module tb_biquad_iir_filter_with_fault_bypass_top;
    import bq_pkg::*;
    import tb_bq_tracker_pkg::*;

    localparam int       CYCLE_LIMIT   = 400000;
    localparam int       LONG_STALL    = 400;
    localparam int       STALL_AT      = 600;
    localparam int       DRAIN_CYCLES  = 4;
    localparam int       NUM_PHASES    = 10;
    localparam int       NUM_CHUNKS    = 5;
    localparam int       CHUNK_ITEMS   = 30;
    localparam t_cfg_idx REG_UNUSED_LO = 3'd6;
    localparam t_cfg_idx REG_UNUSED_HI = 3'd7;
    localparam t_coef    COEF_MAX      = t_coef'(131071);
    localparam t_coef    COEF_MIN      = t_coef'(-131072);

    typedef enum int {MIX_STABLE, MIX_FULL, MIX_EXTREME, MIX_BYPASS} t_mix;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    t_cfg_idx             i_cfg_index;
    logic [COEF_BITS-1:0] i_cfg_data;

    bq_sample_in_if  sample_if();
    bq_sample_out_if result_if();

    biquad_iir_filter_with_fault_bypass_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (sample_if),
        .o_result    (result_if)
    );

    biquad_tracker sb = new();

    int    src_idle_pct;
    int    snk_idle_pct;
    int    stall_left      = 0;
    bit    long_stall_done = 1'b0;
    int    cycle_count     = 0;
    int    reg_writes;
    t_coef cur_a2;

    // Clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_biquad_iir_filter_with_fault_bypass_top: done, errors");
            $finish;
        end
    end

    // Receiver: random holds, plus one long hold-off once traffic is flowing
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            result_if.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end else if (!long_stall_done && sb.samples_in >= STALL_AT) begin
            result_if.ready <= 1'b0;
            stall_left      <= LONG_STALL;
            long_stall_done <= 1'b1;
        end else begin
            result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Note accepted input transactions
    always @(posedge i_clk) begin
        if (i_rst_n && sample_if.valid && sample_if.ready)
            sb.take_sample(sample_if.sample_in);
    end

    // Check accepted output transactions
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready)
            sb.check_output(result_if.sample_out, result_if.passed_through);
    end

    // Offer one sample after a random gap; return at the edge that accepts it
    task automatic send_sample(input t_sample s);
        while ($urandom_range(99) < src_idle_pct) begin
            sample_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_if.valid     <= 1'b1;
        sample_if.sample_in <= s;
        do @(posedge i_clk); while (!sample_if.ready);
    endtask

    // Wait until every expected output has come back
    task automatic wait_drain();
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Send a batch, drop valid, then drain
    task automatic play(input t_sample xs[$]);
        foreach (xs[i])
            send_sample(xs[i]);
        sample_if.valid <= 1'b0;
        wait_drain();
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [COEF_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        reg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_coef coef_for(t_mix mix, t_cfg_idx idx, t_coef a2_now);
        int lim;
        case (mix)
            MIX_FULL:    return t_coef'($urandom);
            MIX_EXTREME: return $urandom_range(1) ? COEF_MAX : COEF_MIN;
            default: begin
                // keep poles inside the unit circle most of the time
                if (idx == REG_A2)
                    return t_coef'(int'($urandom_range(90000)) - 45000);
                if (idx == REG_A1) begin
                    lim = ((65536 + int'(a2_now)) * 9) / 10;
                    return t_coef'(int'($urandom_range(2 * lim)) - lim);
                end
                return t_coef'(int'($urandom_range(65535)) - 32768);
            end
        endcase
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? t_sample'(32767) : t_sample'(-32768);
            1, 2, 3: return t_sample'(int'($urandom_range(16383)) - 8192);
            4:       return t_sample'(int'($urandom_range(63)) - 32);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_BITS-1:0] bypass_word(bit on);
        logic [COEF_BITS-1:0] w;
        w    = COEF_BITS'($urandom);
        w[0] = on;
        return w;
    endfunction

    // Load a full coefficient set for a phase
    task automatic load_coefs(input t_mix mix);
        cur_a2 = coef_for(mix, REG_A2, '0);
        write_reg(REG_A2, cur_a2);
        write_reg(REG_A1, coef_for(mix, REG_A1, cur_a2));
        write_reg(REG_B0, coef_for(mix, REG_B0, cur_a2));
        write_reg(REG_B1, coef_for(mix, REG_B1, cur_a2));
        write_reg(REG_B2, coef_for(mix, REG_B2, cur_a2));
        write_reg(REG_BYPASS, bypass_word(mix == MIX_BYPASS));
    endtask

    // Rewrite one register between chunks; keeps delays unless bypass goes on
    task automatic rewrite_one(input t_mix mix);
        t_cfg_idx idx;
        idx = t_cfg_idx'($urandom_range(7));
        if (idx == REG_BYPASS)
            write_reg(idx, bypass_word(mix == MIX_BYPASS || $urandom_range(3) == 0));
        else if (idx == REG_UNUSED_LO || idx == REG_UNUSED_HI)
            write_reg(idx, COEF_BITS'($urandom));
        else begin
            if (idx == REG_A2)
                cur_a2 = coef_for(mix, idx, cur_a2);
            write_reg(idx, (idx == REG_A2) ? cur_a2 : coef_for(mix, idx, cur_a2));
        end
    endtask

    initial begin
        t_sample xs[$];
        t_mix    mix;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = REG_B0;
        i_cfg_data          = '0;
        sample_if.valid     = 1'b0;
        sample_if.sample_in = '0;
        src_idle_pct        = 8;
        snk_idle_pct        = 8;
        reg_writes          = 0;
        cur_a2              = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bypass at reset: extremes pass straight through
        play('{-32768, 32767, 0});

        // Unity b0, bypass off with upper data bits set
        write_reg(REG_BYPASS, 18'h3fffe);
        play('{32767, -32768, 1, -1});

        // Extreme coefficients
        write_reg(REG_B0, COEF_MAX);
        write_reg(REG_B1, COEF_MIN);
        write_reg(REG_B2, COEF_MAX);
        write_reg(REG_A1, COEF_MIN);
        write_reg(REG_A2, COEF_MAX);
        play('{16384, -16384, -32768});

        // Bypass on clears the delays
        write_reg(REG_BYPASS, 18'h00001);
        play('{-7});

        // Minimum coefficient times minimum sample overflows the output
        write_reg(REG_B0, COEF_MIN);
        write_reg(REG_B1, '0);
        write_reg(REG_B2, '0);
        write_reg(REG_A2, '0);
        write_reg(REG_A1, COEF_MIN);
        write_reg(REG_BYPASS, '0);
        play('{-32768});

        // Unstable pole: output doubles until it trips
        write_reg(REG_B0, COEF_ONE);
        play('{1000, 0, 0, 0, 0, 0, 0});
        play('{3});

        // Writes beyond the register list leave the fault latched
        write_reg(REG_UNUSED_LO, COEF_MAX);
        write_reg(REG_UNUSED_HI, '0);
        play('{-3});

        // A coefficient write clears the fault
        write_reg(REG_A1, '0);
        play('{32767, -32768});

        // Random phases; the first one runs without idling on either side
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       mix = MIX_STABLE;
                1:       mix = MIX_EXTREME;
                2:       mix = MIX_BYPASS;
                3:       mix = MIX_FULL;
                default: mix = ($urandom_range(3) == 0) ? MIX_FULL : MIX_STABLE;
            endcase
            src_idle_pct = (phase == 0) ? 0 : 8;
            snk_idle_pct = (phase == 0) ? 0 : 8;
            load_coefs(mix);
            for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
                xs.delete();
                repeat (CHUNK_ITEMS) xs.push_back(pick_sample());
                play(xs);
                if ($urandom_range(99) < 60)
                    rewrite_one(mix);
            end
        end

        wait_drain();
        repeat (20) @(posedge i_clk);

        $display("run covered %0d samples: %0d filtered, %0d passed through, %0d fault trips",
                 sb.samples_in, sb.filtered_cnt, sb.passed_cnt, sb.faults_cnt);
        $display("%0d register writes, %0d mismatches", reg_writes, sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb_biquad_iir_filter_with_fault_bypass_top: done, clean");
        else
            $display("tb_biquad_iir_filter_with_fault_bypass_top: done, errors");
        $finish;
    end

endmodule
